// ===== sv/fmpo_pkg.sv =====
// ----------------------------------------------------------------------------
// fmpo_pkg: shared types and constants of the feedback FM pulse oscillator
// The sequencer state type and the register index codes.
// ----------------------------------------------------------------------------
package fmpo_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORE_MUL,
        ST_CORE_ROM,
        ST_CORE_INT,
        ST_CORE_NF,
        ST_CORE_NORM,
        ST_CORE_DONE,
        ST_OUT,
        ST_DER_D2,
        ST_DER_D4,
        ST_DER_DIV,
        ST_DER_DONE
    } fmpo_state_t;

    localparam logic REG_PHASE_INC   = 1'b0;
    localparam logic REG_PULSE_WIDTH = 1'b1;

endpackage

// ===== sv/feedback_fm_pulse_oscillator_top.sv =====
// ----------------------------------------------------------------------------
// feedback_fm_pulse_oscillator_top: band-limited pulse oscillator
// Two feedback FM sawtooth cores, one beat of pulse output per input beat.
// ----------------------------------------------------------------------------
// Each input beat (tdata bit 0 = restart) yields one signed Q1.15 pulse sample.
// The two cores are evaluated one after the other on a single shared
// multiplier under a small sequencer. The sample is registered once both
// cores are done, and no new beat is taken before both cores are through.
// The next beat is taken while the result register still waits. The next
// sample is held back only if the previous one has not yet been taken.
// A write to phase_inc starts a derivation of beta, offset and reciprocal.
// The reciprocal is found by a restoring divider at one quotient bit per
// cycle, so the block takes no beat until that derivation is done.
// After reset the same derivation runs once for a zero increment before the
// first beat is taken.
// ----------------------------------------------------------------------------
module feedback_fm_pulse_oscillator_top
    import fmpo_pkg::*;
#(
    parameter int PHASE_BITS      = 24,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [7:0]               s_tdata,   // [0] restart
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata, // sample from bit 0
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [PHASE_BITS-1:0]    cfg_data
);
    localparam int P  = PHASE_BITS;
    localparam int T  = SINE_TABLE_BITS;
    localparam int FB = P - T;
    localparam int N  = 1 << T;
    localparam int Q  = N / 4;                  // entries per quarter wave
    localparam int QS = T - 2;
    localparam int DB = P + 18;                 // dividend width for 2^(17+P)
    localparam int MW = 64;
    localparam int MAW = (P + 1 > 32) ? P + 1 : 32;
    localparam int MBW = (P + 1 > 25) ? P + 1 : 25;
    localparam int PW  = MAW + MBW;
    localparam longint ONE      = longint'(1) << P;
    localparam longint WMAX     = (49 * ONE) / 100;
    localparam longint PW_LO    = (ONE + 50) / 100;
    localparam longint PW_HI    = (99 * ONE + 50) / 100;
    localparam longint NFLOOR   = (ONE + 500) / 1000;
    localparam longint DC_BASE  = 1577058;
    localparam longint DC_SLOPE = 3154117;
    localparam int OW = ((SAMPLE_BITS + 7) / 8) * 8;

    // Sine table in Q2.22, quarter-wave Taylor series in Q2.30.
    logic signed [23:0] sine_rom [N];
    for (genvar k = 0; k < N; k++) begin : g_sine
        localparam longint unsigned QUAD = longint'(k) >> QS;
        localparam longint unsigned R    = longint'(k) & longint'(Q - 1);
        localparam longint unsigned ARG  = ((QUAD & 1) != 0) ? (Q - R) : R;
        localparam longint unsigned X    = (64'd1686629713 * ARG + Q / 2) >> QS;
        localparam longint unsigned X2   = (X * X) >> 30;
        localparam longint unsigned TY0  = 64'd1 << 30;
        localparam longint unsigned TY1  = TY0 - ((X2 * TY0) >> 30) / 156;
        localparam longint unsigned TY2  = TY0 - ((X2 * TY1) >> 30) / 110;
        localparam longint unsigned TY3  = TY0 - ((X2 * TY2) >> 30) / 72;
        localparam longint unsigned TY4  = TY0 - ((X2 * TY3) >> 30) / 42;
        localparam longint unsigned TY5  = TY0 - ((X2 * TY4) >> 30) / 20;
        localparam longint unsigned TY6  = TY0 - ((X2 * TY5) >> 30) / 6;
        localparam longint unsigned S    = (((X * TY6) >> 30) + 128) >> 8;
        localparam logic signed [23:0] ENTRY = (QUAD >= 2) ? -24'(S) : 24'(S);
        assign sine_rom[k] = ENTRY;
    end

    // Round-half-away shift of a signed product.
    function automatic logic signed [MW-1:0] rsh(input logic signed [MW-1:0] v,
                                                 input int s);
        logic [MW-1:0] m;
        m = v[MW-1] ? -v : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return v[MW-1] ? -$signed(m) : $signed(m);
    endfunction

    fmpo_state_t state_reg, state_next;

    logic [P-2:0] inc_reg;
    logic [P-1:0] pw_reg, lead_ph_reg, ph_reg;
    logic signed [23:0] lfb_reg, lprev_reg, tfb_reg, tprev_reg;
    logic signed [23:0] beta_reg, dc_reg;
    logic signed [31:0] lead_out_reg;
    logic [23:0] recip_reg;
    logic signed [24:0] nf_reg;
    logic signed [31:0] v_reg;
    logic core_reg;                       // 0 leading, 1 trailing
    logic [P-1:0] fp_reg;
    logic signed [23:0] ra_reg, rb_reg;
    logic [P-1:0] d2_reg;
    logic [DB-1:0] rem_reg, quo_reg;
    logic [P:0] norm_reg;
    logic [6:0] cnt_reg;
    logic [SAMPLE_BITS-1:0] out_reg;
    logic out_valid_reg;
    logic start_der_reg;

    // The result register is free when empty or being taken this cycle.
    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // Shared multiplier.
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [MW-1:0] mul_x;
    assign mul_p = mul_a * mul_b;
    assign mul_x = MW'(mul_p);

    logic signed [23:0] cur_fb, cur_prev;
    assign cur_fb   = core_reg ? tfb_reg   : lfb_reg;
    assign cur_prev = core_reg ? tprev_reg : lprev_reg;

    logic [P-1:0] d_val;
    assign d_val = P'(ONE / 2) - P'(inc_reg);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_CORE_MUL: begin mul_a = MAW'(cur_fb); mul_b = MBW'(beta_reg); end
            ST_CORE_INT: begin
                mul_a = MAW'(rb_reg) - MAW'(ra_reg);
                mul_b = $signed(MBW'(fp_reg[FB-1:0]));
            end
            ST_CORE_NORM: begin mul_a = MAW'(v_reg); mul_b = $signed(MBW'(recip_reg)); end
            ST_DER_D2: begin mul_a = $signed(MAW'(d_val)); mul_b = $signed(MBW'(d_val)); end
            ST_DER_D4: begin mul_a = $signed(MAW'(d2_reg)); mul_b = $signed(MBW'(d2_reg)); end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start_der_reg) state_next = ST_DER_D2;
                else if (s_tvalid && s_tready) state_next = ST_CORE_MUL;
            ST_CORE_MUL:  state_next = ST_CORE_ROM;
            ST_CORE_ROM:  state_next = ST_CORE_INT;
            ST_CORE_INT:  state_next = ST_CORE_NF;
            ST_CORE_NF:   state_next = ST_CORE_NORM;
            ST_CORE_NORM: state_next = ST_CORE_DONE;
            ST_CORE_DONE: state_next = core_reg ? ST_OUT : ST_CORE_MUL;
            ST_OUT:       if (out_free) state_next = ST_IDLE;
            ST_DER_D2:    state_next = ST_DER_D4;
            ST_DER_D4:    state_next = ST_DER_DIV;
            ST_DER_DIV:   if (cnt_reg == 7'(DB - 1)) state_next = ST_DER_DONE;
            ST_DER_DONE:  state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        s_tready = (state_reg == ST_IDLE) && !start_der_reg;
        m_tvalid = out_valid_reg;
        m_tdata  = OW'(out_reg);
    end

    logic [P-2:0] inc_sat;
    logic [P-1:0] pw_sat;
    assign inc_sat = (longint'(cfg_data[P-2:0]) > WMAX) ? (P-1)'(WMAX) : cfg_data[P-2:0];
    assign pw_sat  = (longint'(cfg_data) < PW_LO) ? P'(PW_LO) :
                     (longint'(cfg_data) > PW_HI) ? P'(PW_HI) : cfg_data;

    logic [T-1:0] idx;
    assign idx = fp_reg[P-1:FB];

    logic signed [MW-1:0] sh, vnorm, sfull, sdiff;
    logic signed [MW-1:0] interp, nf_w, v_w;
    logic [DB:0] rem_try;
    logic [P:0] norm_w;
    always_comb begin
        sh     = rsh(mul_x, 44 - P);
        interp = MW'(ra_reg) + rsh(mul_x, FB);
        nf_w   = rsh(MW'(cur_fb) + MW'(nf_reg), 1);
        v_w    = 5 * nf_w - 3 * MW'(cur_prev) - 2 * MW'(dc_reg);
        vnorm  = rsh(mul_x, 18);
        sdiff  = MW'(lead_out_reg) - MW'(v_reg);
        sfull  = rsh(sdiff <<< (SAMPLE_BITS - 1), 22);
        rem_try = {rem_reg, quo_reg[DB-1]} - {{(DB-P){1'b0}}, norm_reg};
        norm_w = (P+1)'(ONE) - (P+1)'({inc_reg, 1'b0});
        if (longint'(norm_w) < NFLOOR) norm_w = (P+1)'(NFLOOR);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            inc_reg <= '0;
            pw_reg <= P'(ONE / 2);
            lead_ph_reg <= '0;
            lfb_reg <= '0; lprev_reg <= '0; tfb_reg <= '0; tprev_reg <= '0;
            out_valid_reg <= 1'b0;
            start_der_reg <= 1'b1;
            core_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_OUT && out_free) out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready) out_valid_reg <= 1'b0;
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_PHASE_INC:   begin inc_reg <= inc_sat; start_der_reg <= 1'b1; end
                    REG_PULSE_WIDTH: pw_reg <= pw_sat;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                    if (!start_der_reg && s_tvalid && s_tready) begin
                        core_reg <= 1'b0;
                        if (s_tdata[0]) begin
                            lfb_reg <= '0; lprev_reg <= '0; tfb_reg <= '0; tprev_reg <= '0;
                            ph_reg <= '0;
                            lead_ph_reg <= '0;
                        end else ph_reg <= lead_ph_reg;
                    end
                ST_CORE_MUL: fp_reg <= ph_reg + P'(sh);
                ST_CORE_ROM: begin
                    ra_reg <= sine_rom[idx];
                    rb_reg <= sine_rom[idx + T'(1)];
                end
                ST_CORE_INT: nf_reg <= 25'(interp);
                ST_CORE_NF: begin
                    v_reg <= 32'(v_w);
                    if (core_reg) begin tfb_reg <= 24'(nf_w); tprev_reg <= 24'(nf_w); end
                    else begin lfb_reg <= 24'(nf_w); lprev_reg <= 24'(nf_w); end
                end
                ST_CORE_NORM: v_reg <= 32'(vnorm);
                ST_CORE_DONE:
                    if (!core_reg) begin
                        lead_out_reg <= v_reg;
                        lead_ph_reg <= lead_ph_reg + P'(inc_reg);
                        ph_reg <= lead_ph_reg + P'(inc_reg) + pw_reg;
                        core_reg <= 1'b1;
                    end
                ST_OUT:
                    if (out_free) begin
                        if (sfull > MW'((longint'(1) << (SAMPLE_BITS-1)) - 1))
                            out_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                        else if (sfull < -MW'(longint'(1) << (SAMPLE_BITS-1)))
                            out_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                        else out_reg <= SAMPLE_BITS'(sfull);
                    end
                ST_DER_D2: begin
                    start_der_reg <= 1'b0;
                    d2_reg <= P'((mul_x + MW'(ONE / 2)) >>> P);
                    norm_reg <= norm_w;
                    rem_reg <= '0;
                    quo_reg <= DB'(longint'(1) << (17 + P));
                    cnt_reg <= '0;
                    dc_reg <= 24'(DC_BASE - ((DC_SLOPE * longint'(inc_reg) + ONE / 2) >> P));
                end
                ST_DER_D4:
                    beta_reg <= 24'((((longint'(13) *
                        ((mul_x + MW'(ONE / 2)) >>> P)) << 22) + ONE / 2) >> P);
                ST_DER_DIV: begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (!rem_try[DB]) begin
                        rem_reg <= rem_try[DB-1:0];
                        quo_reg <= {quo_reg[DB-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[DB-2:0], quo_reg[DB-1]};
                        quo_reg <= {quo_reg[DB-2:0], 1'b0};
                    end
                end
                ST_DER_DONE: begin
                    // Round: add one when twice the remainder reaches the divisor.
                    if (({1'b0, rem_reg} << 1) >= (DB+1)'(norm_reg)) begin
                        recip_reg <= (quo_reg + DB'(1) > DB'(24'hFFFFFF)) ? 24'hFFFFFF
                                     : 24'(quo_reg + DB'(1));
                    end else begin
                        recip_reg <= (quo_reg > DB'(24'hFFFFFF)) ? 24'hFFFFFF
                                     : 24'(quo_reg);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
